@@ hw/rtl/wia_pkg.sv @@
// package: item types and operation codes for the wide integer unit
`timescale 1ns / 1ps
package wia_pkg;

	typedef enum logic [3:0] {
		FN_LOADA = 4'd0,
		FN_LOADB = 4'd1,
		FN_READA = 4'd2,
		FN_ADD   = 4'd3,
		FN_SUB   = 4'd4,
		FN_MUL   = 4'd5,
		FN_DIV   = 4'd6,
		FN_MOD   = 4'd7,
		FN_SHL   = 4'd8,
		FN_SHR   = 4'd9,
		FN_AND   = 4'd10,
		FN_OR    = 4'd11,
		FN_XOR   = 4'd12,
		FN_INC   = 4'd13,
		FN_DEC   = 4'd14,
		FN_CMP   = 4'd15
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [2:0]  word_index;
		logic [31:0] data_word;
		logic [7:0]  shift_amount;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        a_less;
		logic        a_equal;
		logic        a_greater;
		logic        div_zero;
	} out_item_t;

endpackage

@@ hw/rtl/wide_integer_alu.sv @@
// top level: wide unsigned integer unit with limb-serial sequencer
// path, accept to result: loads, reads, bitwise ops and divide by zero go to the output
// state; add, sub, inc, dec, cmp and shifts step limb by limb; multiply steps through the
// partial products; divide and remainder shift, limb compare, then limb subtract per bit
// one item at a time; next item accepted the cycle after the result is taken
// reset clears both A and B to zero and empties the output register
`timescale 1ns / 1ps
module wide_integer_alu #(
	parameter int BITS  = 256,
	parameter int LIMBS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  wia_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output wia_pkg::out_item_t out_data
);

	localparam int LW = (LIMBS > 1) ? $clog2(LIMBS) : 1;
	localparam int BW = $clog2(BITS);
	localparam int CW = $clog2(LIMBS + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_LIMB, ST_MUL, ST_DSHIFT, ST_DCMP, ST_DSUB, ST_DONE, ST_OUT
	} state_t;

	state_t             state_q;
	wia_pkg::func_t     func_q;
	logic [31:0]        a_q [LIMBS];
	logic [31:0]        b_q [LIMBS];
	logic [31:0]        t_q [LIMBS];
	logic [31:0]        r_q [LIMBS];
	logic [LW-1:0]      i_q, j_q;
	logic [CW-1:0]      k_q;
	logic [BW-1:0]      bit_q;
	logic [BW-1:0]      sh_q;
	logic [32:0]        carry_q;
	logic               flag_q;
	logic [1:0]         cmp_q;
	logic               out_q;
	wia_pkg::out_item_t res_q;

	// shared 32x32 multiply-accumulate and add/subtract
	logic [63:0] mac;
	logic [32:0] addsub;
	logic [31:0] opa, opb;
	logic        sub_en;
	logic [LW-1:0] lidx;

	assign in_stall = (state_q != ST_IDLE) || out_q;
	assign out_valid = out_q;
	assign out_data = res_q;
	assign lidx = k_q[LW-1:0];

	always_comb begin
		mac = 64'(a_q[i_q]) * 64'(b_q[j_q]) + 64'(t_q[LW'(i_q + j_q)]) + 64'(carry_q[31:0]);
		opa = (state_q == ST_DSUB) ? r_q[lidx] : a_q[lidx];
		opb = b_q[lidx];
		sub_en = (state_q == ST_DSUB) || (func_q == wia_pkg::FN_SUB) ||
			(func_q == wia_pkg::FN_CMP) || (func_q == wia_pkg::FN_DEC);
		if (func_q == wia_pkg::FN_INC || func_q == wia_pkg::FN_DEC)
			opb = 32'(carry_q[0]);
		if (sub_en)
			addsub = {1'b0, opa} - {1'b0, opb} - 33'(carry_q[0]);
		else
			addsub = {1'b0, opa} + {1'b0, opb} + 33'(carry_q[0]);
		if (func_q == wia_pkg::FN_INC || func_q == wia_pkg::FN_DEC)
			addsub = sub_en ? ({1'b0, opa} - {1'b0, opb}) : ({1'b0, opa} + {1'b0, opb});
	end

	// shift: one output limb per cycle, built bit by bit from the source
	function automatic logic [31:0] shift_limb(input logic [31:0] src [LIMBS],
			input logic [LW-1:0] li, input logic [BW-1:0] amt, input logic left);
		logic [31:0] v;
		int p;
		v = '0;
		for (int b = 0; b < 32; b++) begin
			p = int'(li) * 32 + b + (left ? -int'(amt) : int'(amt));
			if (p >= 0 && p < BITS)
				v[b] = src[p / 32][p % 32];
		end
		return v;
	endfunction

	// shift count modulo BITS by repeated compare and subtract
	function automatic logic [BW-1:0] shift_mod_f(input logic [7:0] amt);
		logic [8:0] v;
		v = {1'b0, amt};
		for (int n = 0; n < 4; n++)
			if (32'(v) >= BITS) v = v - 9'(BITS);
		return BW'(v);
	endfunction

	// B all zero, as an or-reduction over the limbs
	function automatic logic b_zero_f(input logic [31:0] v [LIMBS]);
		logic z;
		z = 1'b1;
		for (int n = 0; n < LIMBS; n++)
			if (v[n] != 32'd0) z = 1'b0;
		return z;
	endfunction

	// sequencer, datapath registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_q   <= 1'b0;
			for (int n = 0; n < LIMBS; n++) begin
				a_q[n] <= '0;
				b_q[n] <= '0;
			end
		end else begin
			if (out_q && !out_stall)
				out_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						func_q  <= in_data.func;
						res_q.read_data <= (in_data.func == wia_pkg::FN_READA &&
							32'(in_data.word_index) < LIMBS) ?
							a_q[LW'(in_data.word_index)] : '0;
						res_q.a_less    <= 1'b0;
						res_q.a_equal   <= 1'b0;
						res_q.a_greater <= 1'b0;
						res_q.div_zero  <= (in_data.func == wia_pkg::FN_DIV ||
							in_data.func == wia_pkg::FN_MOD) && b_zero_f(b_q);
						k_q     <= '0;
						i_q     <= '0;
						j_q     <= '0;
						cmp_q   <= 2'd0;
						flag_q  <= 1'b0;
						carry_q <= 33'(in_data.func == wia_pkg::FN_INC ||
							in_data.func == wia_pkg::FN_DEC);
						sh_q    <= shift_mod_f(in_data.shift_amount);
						bit_q   <= BW'(BITS - 1);
						for (int n = 0; n < LIMBS; n++) begin
							t_q[n] <= '0;
							r_q[n] <= '0;
						end
						unique case (in_data.func)
							wia_pkg::FN_LOADA: begin
								if (32'(in_data.word_index) < LIMBS)
									a_q[LW'(in_data.word_index)] <= in_data.data_word;
								state_q <= ST_OUT;
							end
							wia_pkg::FN_LOADB: begin
								if (32'(in_data.word_index) < LIMBS)
									b_q[LW'(in_data.word_index)] <= in_data.data_word;
								state_q <= ST_OUT;
							end
							wia_pkg::FN_READA: state_q <= ST_OUT;
							wia_pkg::FN_AND, wia_pkg::FN_OR, wia_pkg::FN_XOR: begin
								for (int n = 0; n < LIMBS; n++)
									a_q[n] <= (in_data.func == wia_pkg::FN_AND) ? a_q[n] & b_q[n] :
										(in_data.func == wia_pkg::FN_OR) ? a_q[n] | b_q[n] :
										a_q[n] ^ b_q[n];
								state_q <= ST_OUT;
							end
							wia_pkg::FN_MUL: state_q <= ST_MUL;
							// division by zero answers at once and leaves A
							wia_pkg::FN_DIV, wia_pkg::FN_MOD: begin
								if (b_zero_f(b_q)) state_q <= ST_OUT;
								else state_q <= ST_DSHIFT;
							end
							default: state_q <= ST_LIMB;
						endcase
					end
				end
				ST_LIMB: begin
					// one limb per cycle through the add/subtract unit or shifter
					if (func_q == wia_pkg::FN_SHL || func_q == wia_pkg::FN_SHR)
						t_q[lidx] <= shift_limb(a_q, lidx, sh_q, func_q == wia_pkg::FN_SHL);
					else if (func_q == wia_pkg::FN_CMP) begin
						if (addsub[31:0] != 32'd0 || addsub[32])
							cmp_q <= addsub[32] ? 2'd1 : 2'd2;
						carry_q <= '0;
					end else begin
						a_q[lidx] <= addsub[31:0];
						carry_q   <= 33'(addsub[32]);
					end
					if (32'(k_q) == LIMBS - 1) state_q <= ST_DONE;
					k_q <= k_q + 1'b1;
				end
				ST_MUL: begin
					// one partial product per cycle, rows truncated at LIMBS
					t_q[LW'(i_q + j_q)] <= mac[31:0];
					if (32'(i_q) + 32'(j_q) == LIMBS - 1) begin
						carry_q <= '0;
						j_q <= '0;
						if (32'(i_q) == LIMBS - 1) state_q <= ST_DONE;
						else i_q <= i_q + 1'b1;
					end else begin
						carry_q <= {1'b0, mac[63:32]};
						j_q <= j_q + 1'b1;
					end
				end
				ST_DSHIFT: begin
					// bring next dividend bit into remainder
					flag_q <= r_q[LIMBS-1][31];
					for (int n = LIMBS - 1; n > 0; n--)
						r_q[n] <= {r_q[n][30:0], r_q[n-1][31]};
					r_q[0] <= {r_q[0][30:0], a_q[bit_q[BW-1:5]][bit_q[4:0]]};
					k_q <= CW'(LIMBS - 1);
					cmp_q <= 2'd0;
					state_q <= ST_DCMP;
				end
				ST_DCMP: begin
					// compare remainder with B from the top limb down
					if (cmp_q == 2'd0 && (flag_q || r_q[lidx] != b_q[lidx])) begin
						cmp_q <= (flag_q || r_q[lidx] > b_q[lidx]) ? 2'd2 : 2'd1;
					end
					if (32'(k_q) == 0) begin
						k_q <= '0;
						carry_q <= '0;
						if (cmp_q == 2'd2 || (cmp_q == 2'd0 &&
								(flag_q || r_q[lidx] >= b_q[lidx]))) begin
							t_q[bit_q[BW-1:5]][bit_q[4:0]] <= 1'b1;
							state_q <= ST_DSUB;
						end else if (bit_q == '0) state_q <= ST_DONE;
						else begin
							bit_q <= bit_q - 1'b1;
							state_q <= ST_DSHIFT;
						end
					end else k_q <= k_q - 1'b1;
				end
				ST_DSUB: begin
					r_q[lidx] <= addsub[31:0];
					carry_q <= 33'(addsub[32]);
					if (32'(k_q) == LIMBS - 1) begin
						if (bit_q == '0) state_q <= ST_DONE;
						else begin
							bit_q <= bit_q - 1'b1;
							state_q <= ST_DSHIFT;
						end
					end
					k_q <= k_q + 1'b1;
				end
				ST_DONE: begin
					unique case (func_q)
						wia_pkg::FN_SHL, wia_pkg::FN_SHR, wia_pkg::FN_MUL:
							for (int n = 0; n < LIMBS; n++) a_q[n] <= t_q[n];
						wia_pkg::FN_DIV:
							for (int n = 0; n < LIMBS; n++) a_q[n] <= t_q[n];
						wia_pkg::FN_MOD:
							for (int n = 0; n < LIMBS; n++) a_q[n] <= r_q[n];
						wia_pkg::FN_CMP: begin
							res_q.a_less    <= (cmp_q == 2'd1);
							res_q.a_equal   <= (cmp_q == 2'd0);
							res_q.a_greater <= (cmp_q == 2'd2);
						end
						default: ;
					endcase
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_q   <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ test/tb_wide_integer_alu.sv @@
// testbench: random and directed item checking of the wide integer unit against a local model
`timescale 1ns / 1ps
module tb_wide_integer_alu;

	localparam int WIDTH = 256;

	typedef struct {
		wia_pkg::in_item_t item;
		bit                drain_first;
	} pending_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	wia_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	wia_pkg::out_item_t out_data;

	pending_t           pending_q[$];
	wia_pkg::out_item_t expected_q[$];
	logic [WIDTH-1:0] acc_val = '0;
	logic [WIDTH-1:0] opnd_val = '0;
	int          accepted_cnt = 0;
	int          error_cnt = 0;
	bit          in_fire = 1'b0;

	wide_integer_alu u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predict the result of one item and update the local accumulator and operand
	function automatic wia_pkg::out_item_t predict_alu(wia_pkg::in_item_t it);
		wia_pkg::out_item_t r;
		r = '0;
		case (it.func)
			wia_pkg::FN_LOADA: acc_val[it.word_index*32 +: 32] = it.data_word;
			wia_pkg::FN_LOADB: opnd_val[it.word_index*32 +: 32] = it.data_word;
			wia_pkg::FN_READA: r.read_data = acc_val[it.word_index*32 +: 32];
			wia_pkg::FN_ADD:   acc_val = acc_val + opnd_val;
			wia_pkg::FN_SUB:   acc_val = acc_val - opnd_val;
			wia_pkg::FN_MUL:   acc_val = acc_val * opnd_val;
			wia_pkg::FN_DIV, wia_pkg::FN_MOD: begin
				if (opnd_val == '0) r.div_zero = 1'b1;
				else if (it.func == wia_pkg::FN_DIV) acc_val = acc_val / opnd_val;
				else acc_val = acc_val % opnd_val;
			end
			wia_pkg::FN_SHL:   acc_val = acc_val << it.shift_amount;
			wia_pkg::FN_SHR:   acc_val = acc_val >> it.shift_amount;
			wia_pkg::FN_AND:   acc_val = acc_val & opnd_val;
			wia_pkg::FN_OR:    acc_val = acc_val | opnd_val;
			wia_pkg::FN_XOR:   acc_val = acc_val ^ opnd_val;
			wia_pkg::FN_INC:   acc_val = acc_val + 1'b1;
			wia_pkg::FN_DEC:   acc_val = acc_val - 1'b1;
			default: begin
				r.a_less    = acc_val < opnd_val;
				r.a_equal   = acc_val == opnd_val;
				r.a_greater = acc_val > opnd_val;
			end
		endcase
		return r;
	endfunction

	// idle percentages per phase: sender then receiver
	function automatic bit sender_idles();
		if (accepted_cnt < 220) return $urandom_range(99) < 22;
		if (accepted_cnt < 420) return $urandom_range(99) < 54;
		return 1'b0;
	endfunction

	function automatic bit receiver_stalls();
		if (accepted_cnt < 220) return $urandom_range(99) < 54;
		if (accepted_cnt < 420) return $urandom_range(99) < 22;
		return 1'b0;
	endfunction

	// record accepted items and predict their results
	always @(posedge clk) begin
		in_fire <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			expected_q.push_back(predict_alu(in_data));
			accepted_cnt <= accepted_cnt + 1;
		end
	end

	// driver: new item only once the previous one is taken
	always @(negedge clk) begin
		pending_t nxt;
		if (arst_n) begin
			out_stall <= receiver_stalls();
			if (!in_valid || in_fire) begin
				if (pending_q.size() == 0 || sender_idles() ||
				    (pending_q[0].drain_first && expected_q.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					nxt = pending_q.pop_front();
					in_data  <= nxt.item;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		wia_pkg::out_item_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("result with no item outstanding: %h", out_data);
				error_cnt++;
			end else begin
				exp_r = expected_q.pop_front();
				if (out_data.read_data !== exp_r.read_data) begin
					$error("read_data expected %h actual %h", exp_r.read_data,
					       out_data.read_data);
					error_cnt++;
				end
				if (out_data.a_less !== exp_r.a_less) begin
					$error("a_less expected %b actual %b", exp_r.a_less, out_data.a_less);
					error_cnt++;
				end
				if (out_data.a_equal !== exp_r.a_equal) begin
					$error("a_equal expected %b actual %b", exp_r.a_equal, out_data.a_equal);
					error_cnt++;
				end
				if (out_data.a_greater !== exp_r.a_greater) begin
					$error("a_greater expected %b actual %b", exp_r.a_greater,
					       out_data.a_greater);
					error_cnt++;
				end
				if (out_data.div_zero !== exp_r.div_zero) begin
					$error("div_zero expected %b actual %b", exp_r.div_zero, out_data.div_zero);
					error_cnt++;
				end
			end
		end
	end

	task automatic add_item(wia_pkg::func_t f, int idx, logic [31:0] word, logic [7:0] sh,
	                        bit drain = 1'b0);
		pending_t p;
		p.item.func         = f;
		p.item.word_index   = idx[2:0];
		p.item.data_word    = word;
		p.item.shift_amount = sh;
		p.drain_first       = drain;
		pending_q.push_back(p);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2: return $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	// stimulus
	initial begin
		int n;
		int k;
		wia_pkg::func_t f;
		// division by zero with B still at reset
		add_item(wia_pkg::FN_DIV, 0, 32'h0, 8'h0);
		add_item(wia_pkg::FN_MOD, 7, 32'hffff_ffff, 8'hff);
		for (k = 0; k < 8; k++) add_item(wia_pkg::FN_LOADA, k, 32'hffff_ffff, 8'h0);
		add_item(wia_pkg::FN_CMP, 0, 32'h0, 8'h0);
		add_item(wia_pkg::FN_INC, 0, 32'h0, 8'h0);            // wrap to zero
		add_item(wia_pkg::FN_DEC, 0, 32'h0, 8'h0);            // wrap to all ones
		add_item(wia_pkg::FN_LOADB, 0, 32'h3, 8'h0);
		add_item(wia_pkg::FN_MUL, 0, 32'h0, 8'h0);
		add_item(wia_pkg::FN_ADD, 0, 32'h0, 8'h0);
		add_item(wia_pkg::FN_DIV, 0, 32'h0, 8'h0);
		add_item(wia_pkg::FN_MOD, 0, 32'h0, 8'h0);
		add_item(wia_pkg::FN_SUB, 0, 32'h0, 8'h0);            // underflow
		add_item(wia_pkg::FN_SHL, 0, 32'h0, 8'd0);            // shift by zero leaves A
		add_item(wia_pkg::FN_SHR, 0, 32'h0, 8'd255);
		add_item(wia_pkg::FN_XOR, 0, 32'h0, 8'h0);
		add_item(wia_pkg::FN_OR, 0, 32'h0, 8'h0);
		add_item(wia_pkg::FN_AND, 0, 32'h0, 8'h0);
		add_item(wia_pkg::FN_READA, 7, 32'h0, 8'h0, 1'b1);    // pause until drained
		// random part: about a quarter loads, the rest random items of any operation
		for (n = 0; n < 600; n++) begin
			if ($urandom_range(3) == 0) begin
				f = wia_pkg::func_t'($urandom_range(1));
				add_item(f, $urandom_range(7), rand_word(), 8'h0);
			end else begin
				f = wia_pkg::func_t'($urandom_range(15));
				add_item(f, $urandom_range(7), $urandom, 8'($urandom_range(255)),
				         n == 300);
			end
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_q.size() == 0 && expected_q.size() == 0 && !in_valid);
		repeat (20) @(posedge clk);
		if (error_cnt == 0 && expected_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog
	initial begin
		#40ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ wide_integer_alu.f @@
hw/rtl/wia_pkg.sv
hw/rtl/wide_integer_alu.sv
test/tb_wide_integer_alu.sv
